/* src/fab_pkg.sv */
`timescale 1ns / 1ps

package fab_pkg;

  localparam int AddrW    = 22;
  localparam int OutAddrW = 21;

  localparam logic [AddrW-1:0] HEAP_START_RESET = 22'h001000;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_SPACE  = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    IDX_HOLD  = 3'd0,
    IDX_ZERO  = 3'd1,
    IDX_INC   = 3'd2,
    IDX_DEC   = 3'd3,
    IDX_COUNT = 3'd4
  } idx_op_e;

  // Table read address relative to the next index.
  typedef enum logic [1:0] {
    RD_AT    = 2'd0,
    RD_BELOW = 2'd1,
    RD_ABOVE = 2'd2
  } rd_sel_e;

  typedef struct packed {
    logic    item_load;
    idx_op_e idx_op;
    rd_sel_e rd_sel;
    logic    slot_from_idx;
    logic    slot_from_cnt;
    logic    pos_step;
    logic    mem_we;
    logic    wr_new;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    res_load;
    status_e res_status;
    logic    res_grant;
    logic    out_load;
  } fab_cmd_t;

  typedef struct packed {
    logic item_free;
    logic cnt_zero;
    logic cnt_full;
    logic fit_entry;
    logic fit_end;
    logic at_last;
    logic at_slot;
    logic addr_match;
    logic out_free;
  } fab_stat_t;

  // A gap that ends below the scan position holds only a zero-size block.
  function automatic logic gap_fits(input logic [AddrW:0]   pos,
                                    input logic [AddrW-1:0] limit,
                                    input logic [AddrW-1:0] need);
    logic [AddrW:0] lim_ext;
    lim_ext = {1'b0, limit};
    if (lim_ext < pos) begin
      return (need == '0);
    end
    return ((lim_ext - pos) >= {1'b0, need});
  endfunction

endpackage

/* src/fab_ctrl.sv */
`timescale 1ns / 1ps

module fab_ctrl
  import fab_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  fab_stat_t stat_i,
  output fab_cmd_t  cmd_o
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_START  = 8'b0000_0010,
    ST_SCAN   = 8'b0000_0100,
    ST_FINAL  = 8'b0000_1000,
    ST_SHIFT  = 8'b0001_0000,
    ST_FSCAN  = 8'b0010_0000,
    ST_FSHIFT = 8'b0100_0000,
    ST_RESP   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.idx_op     = IDX_HOLD;
    cmd_o.rd_sel     = RD_AT;
    cmd_o.res_status = STAT_OK;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.item_load = 1'b1;
          state_d = ST_START;
        end
      end
      ST_START: begin
        if (stat_i.item_free) begin
          if (stat_i.cnt_zero) begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = STAT_NOT_FOUND;
            state_d = ST_RESP;
          end else begin
            cmd_o.idx_op = IDX_ZERO;
            cmd_o.rd_sel = RD_AT;
            state_d = ST_FSCAN;
          end
        end else if (stat_i.cnt_full) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = STAT_FULL;
          state_d = ST_RESP;
        end else if (stat_i.cnt_zero) begin
          state_d = ST_FINAL;
        end else begin
          cmd_o.idx_op = IDX_ZERO;
          cmd_o.rd_sel = RD_AT;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat_i.fit_entry) begin
          cmd_o.slot_from_idx = 1'b1;
          cmd_o.idx_op = IDX_COUNT;
          cmd_o.rd_sel = RD_BELOW;
          state_d = ST_SHIFT;
        end else begin
          cmd_o.pos_step = 1'b1;
          if (stat_i.at_last) begin
            state_d = ST_FINAL;
          end else begin
            cmd_o.idx_op = IDX_INC;
            cmd_o.rd_sel = RD_AT;
          end
        end
      end
      ST_FINAL: begin
        if (stat_i.fit_end) begin
          cmd_o.slot_from_cnt = 1'b1;
          cmd_o.idx_op = IDX_COUNT;
          cmd_o.rd_sel = RD_BELOW;
          state_d = ST_SHIFT;
        end else begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = STAT_NO_SPACE;
          state_d = ST_RESP;
        end
      end
      ST_SHIFT: begin
        // Entries move up one place from the top down; the new entry lands last.
        cmd_o.mem_we = 1'b1;
        if (stat_i.at_slot) begin
          cmd_o.wr_new     = 1'b1;
          cmd_o.cnt_inc    = 1'b1;
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = STAT_OK;
          cmd_o.res_grant  = 1'b1;
          state_d = ST_RESP;
        end else begin
          cmd_o.idx_op = IDX_DEC;
          cmd_o.rd_sel = RD_BELOW;
        end
      end
      ST_FSCAN: begin
        if (stat_i.addr_match) begin
          cmd_o.idx_op = IDX_HOLD;
          cmd_o.rd_sel = RD_ABOVE;
          state_d = ST_FSHIFT;
        end else if (stat_i.at_last) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = STAT_NOT_FOUND;
          state_d = ST_RESP;
        end else begin
          cmd_o.idx_op = IDX_INC;
          cmd_o.rd_sel = RD_AT;
        end
      end
      ST_FSHIFT: begin
        if (stat_i.at_last) begin
          cmd_o.cnt_dec    = 1'b1;
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = STAT_OK;
          state_d = ST_RESP;
        end else begin
          cmd_o.mem_we = 1'b1;
          cmd_o.idx_op = IDX_INC;
          cmd_o.rd_sel = RD_ABOVE;
        end
      end
      ST_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* src/fab_dpath.sv */
`timescale 1ns / 1ps

module fab_dpath
  import fab_pkg::*;
#(
  parameter int MAX_BLOCKS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [AddrW-1:0]    heap_start_i,
  input  logic [AddrW-1:0]    heap_end_i,
  input  logic                cmd_i,
  input  logic [AddrW-1:0]    request_size_i,
  input  logic [OutAddrW-1:0] block_address_i,
  output logic [OutAddrW-1:0] granted_address_o,
  output logic [1:0]          status_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  fab_cmd_t            ctl_i,
  output fab_stat_t           stat_o
);

  localparam int IW = $clog2(MAX_BLOCKS + 1);
  localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int EW = 2 * AddrW;

  cmd_e                cmd_q;
  logic [AddrW-1:0]    size_q;
  logic [OutAddrW-1:0] addr_q;
  logic [AddrW:0]      pos_q, pos_d;
  logic [IW-1:0]       idx_q, idx_d;
  logic [IW-1:0]       slot_q;
  logic [IW-1:0]       cnt_q;
  logic [IW-1:0]       rd_idx;
  logic [AW-1:0]       raddr;
  logic [AW-1:0]       waddr;
  logic [EW-1:0]       wdata;
  logic [EW-1:0]       mem_q [MAX_BLOCKS];
  logic [EW-1:0]       rdata_q;
  logic [AddrW-1:0]    ent_start;
  logic [AddrW-1:0]    ent_len;
  logic [AddrW:0]      blk_end;
  status_e             res_status_q;
  logic [OutAddrW-1:0] res_grant_q;
  logic                out_valid_q;
  status_e             out_status_q;
  logic [OutAddrW-1:0] out_addr_q;

  assign ent_start = rdata_q[EW-1:AddrW];
  assign ent_len   = rdata_q[AddrW-1:0];
  assign blk_end   = {1'b0, ent_start} + {1'b0, ent_len};

  always_comb begin
    case (ctl_i.idx_op)
      IDX_HOLD:  idx_d = idx_q;
      IDX_ZERO:  idx_d = '0;
      IDX_INC:   idx_d = idx_q + 1'b1;
      IDX_DEC:   idx_d = idx_q - 1'b1;
      IDX_COUNT: idx_d = cnt_q;
      default:   idx_d = idx_q;
    endcase
  end

  // The read is registered, so the address follows the next index.
  always_comb begin
    case (ctl_i.rd_sel)
      RD_AT:    rd_idx = idx_d;
      RD_BELOW: rd_idx = idx_d - 1'b1;
      RD_ABOVE: rd_idx = idx_d + 1'b1;
      default:  rd_idx = idx_d;
    endcase
  end

  assign raddr = rd_idx[AW-1:0];
  assign waddr = idx_q[AW-1:0];
  assign wdata = ctl_i.wr_new ? {pos_q[AddrW-1:0], size_q} : rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.mem_we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  always_comb begin
    pos_d = pos_q;
    if (ctl_i.item_load) begin
      pos_d = {1'b0, heap_start_i};
    end else if (ctl_i.pos_step && (blk_end > pos_q)) begin
      pos_d = blk_end;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.item_load) begin
      cmd_q  <= cmd_e'(cmd_i);
      size_q <= request_size_i;
      addr_q <= block_address_i;
    end
    pos_q <= pos_d;
    if (ctl_i.res_load) begin
      res_status_q <= ctl_i.res_status;
      res_grant_q  <= ctl_i.res_grant ? pos_q[OutAddrW-1:0] : '0;
    end
    if (ctl_i.out_load) begin
      out_status_q <= res_status_q;
      out_addr_q   <= res_grant_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      slot_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (ctl_i.slot_from_idx) begin
        slot_q <= idx_q;
      end else if (ctl_i.slot_from_cnt) begin
        slot_q <= cnt_q;
      end
      if (ctl_i.cnt_inc) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (ctl_i.cnt_dec) begin
        cnt_q <= cnt_q - 1'b1;
      end
      if (ctl_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.item_free  = (cmd_q == CMD_FREE);
  assign stat_o.cnt_zero   = (cnt_q == '0);
  assign stat_o.cnt_full   = (cnt_q == IW'(MAX_BLOCKS));
  assign stat_o.fit_entry  = gap_fits(pos_q, ent_start, size_q);
  assign stat_o.fit_end    = gap_fits(pos_q, heap_end_i, size_q);
  assign stat_o.at_last    = (idx_q == (cnt_q - 1'b1));
  assign stat_o.at_slot    = (idx_q == slot_q);
  assign stat_o.addr_match = (ent_start == {1'b0, addr_q});
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign granted_address_o = out_addr_q;
  assign status_o          = out_status_q;
  assign out_valid_o       = out_valid_q;

endmodule

/* src/first_fit_block_allocator_core.sv */
`timescale 1ns / 1ps
// One item is in work at a time: the next is accepted only once its result has moved from the
// result register to the output register, and that move waits while the output is still held.
// Reset is asynchronous, active low: bounds return to their defaults and the table empties.

module first_fit_block_allocator_core
  import fab_pkg::*;
#(
  parameter int MAX_BLOCKS = 32,
  parameter int RAM_BYTES  = 2097152
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                cmd_i,
  input  logic [AddrW-1:0]    request_size_i,
  input  logic [OutAddrW-1:0] block_address_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutAddrW-1:0] granted_address_o,
  output logic [1:0]          status_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam logic [AddrW-1:0] HeapEndReset = AddrW'(RAM_BYTES % 4194304);

  logic [AddrW-1:0] heap_start_q;
  logic [AddrW-1:0] heap_end_q;
  logic             cfg_wr;
  fab_cmd_t         ctl;
  fab_stat_t        stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_start_q <= HEAP_START_RESET;
      heap_end_q   <= HeapEndReset;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        heap_end_q <= pwdata[AddrW-1:0];
      end else begin
        heap_start_q <= pwdata[AddrW-1:0];
      end
    end
  end

  assign prdata = paddr[2] ? {{(32-AddrW){1'b0}}, heap_end_q}
                           : {{(32-AddrW){1'b0}}, heap_start_q};

  fab_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (ctl)
  );

  fab_dpath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .heap_start_i      (heap_start_q),
    .heap_end_i        (heap_end_q),
    .cmd_i             (cmd_i),
    .request_size_i    (request_size_i),
    .block_address_i   (block_address_i),
    .granted_address_o (granted_address_o),
    .status_o          (status_o),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .ctl_i             (ctl),
    .stat_o            (stat)
  );

endmodule

/* verif/first_fit_block_allocator_core_tb.sv */
`timescale 1ns / 1ps

module first_fit_block_allocator_core_tb;
  import fab_pkg::*;

  localparam int MAX_ENTRIES = 32;
  localparam int RAM_SIZE    = 2097152;

  localparam logic [2:0] REG_HEAP_START = 3'd0;
  localparam logic [2:0] REG_HEAP_END   = 3'd4;

  localparam logic [AddrW-1:0] SIZE_TOP = 22'h200000;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    cmd_e                cmd;
    logic [AddrW-1:0]    size;
    logic [OutAddrW-1:0] addr;
    logic                pick_live;
  } heap_req_t;

  typedef struct packed {
    logic [OutAddrW-1:0] addr;
    status_e             status;
  } heap_resp_t;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                in_valid_i      = 1'b0;
  logic                in_ready_o;
  logic                cmd_i           = 1'b0;
  logic [AddrW-1:0]    request_size_i  = '0;
  logic [OutAddrW-1:0] block_address_i = '0;
  logic                out_valid_o;
  logic                out_ready_i     = 1'b0;
  logic [OutAddrW-1:0] granted_address_o;
  logic [1:0]          status_o;
  logic                psel            = 1'b0;
  logic                penable         = 1'b0;
  logic                pwrite          = 1'b0;
  logic [2:0]          paddr           = '0;
  logic [31:0]         pwdata          = '0;
  logic [31:0]         prdata;
  logic                pready;

  first_fit_block_allocator_core #(
    .MAX_BLOCKS(MAX_ENTRIES),
    .RAM_BYTES (RAM_SIZE)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .cmd_i            (cmd_i),
    .request_size_i   (request_size_i),
    .block_address_i  (block_address_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .granted_address_o(granted_address_o),
    .status_o         (status_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // Allocator image: bounds and the sorted block list.
  logic [AddrW-1:0] heap_lo = HEAP_START_RESET;
  logic [AddrW-1:0] heap_hi = AddrW'(RAM_SIZE);
  logic [AddrW-1:0] blk_start [MAX_ENTRIES];
  logic [AddrW-1:0] blk_len   [MAX_ENTRIES];
  int               blk_count = 0;

  heap_req_t  pending_reqs[$];
  heap_resp_t awaited_resps[$];
  heap_req_t  cur_req  = '0;
  bit         offering = 1'b0;

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  bit hold_arm     = 1'b0;
  bit hold_taken   = 1'b0;
  int hold_left    = 0;

  int mismatches = 0;
  int n_alloc    = 0;
  int n_free     = 0;
  int n_results  = 0;
  int n_settings = 0;
  int peak_count = 0;
  int outcome_seen [4];

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("first_fit_block_allocator_core_tb: done, errors");
    $finish;
  end

  function automatic void note_mismatch(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, what, want, got);
    end
  endfunction

  // A gap that ends below the scan position only holds a zero-size block.
  function automatic bit room_for(input logic [AddrW:0] from, input logic [AddrW-1:0] upto,
                                  input logic [AddrW-1:0] need);
    if ({1'b0, upto} < from) begin
      return need == '0;
    end
    return ({1'b0, upto} - from) >= {1'b0, need};
  endfunction

  function automatic heap_resp_t place_block(input logic [AddrW-1:0] need);
    heap_resp_t     r;
    logic [AddrW:0] pos;
    logic [AddrW:0] blk_end;
    int             i;
    int             slot;
    bit             hit;
    r.addr   = '0;
    r.status = STAT_OK;
    if (blk_count >= MAX_ENTRIES) begin
      r.status = STAT_FULL;
      return r;
    end
    pos  = {1'b0, heap_lo};
    slot = blk_count;
    hit  = 1'b0;
    for (i = 0; i < blk_count && !hit; i++) begin
      if (room_for(pos, blk_start[i], need)) begin
        slot = i;
        hit  = 1'b1;
      end else begin
        blk_end = {1'b0, blk_start[i]} + {1'b0, blk_len[i]};
        if (blk_end > pos) begin
          pos = blk_end;
        end
      end
    end
    if (!hit && !room_for(pos, heap_hi, need)) begin
      r.status = STAT_NO_SPACE;
      return r;
    end
    for (i = blk_count; i > slot; i--) begin
      blk_start[i] = blk_start[i-1];
      blk_len[i]   = blk_len[i-1];
    end
    blk_start[slot] = pos[AddrW-1:0];
    blk_len[slot]   = need;
    blk_count++;
    r.addr = pos[OutAddrW-1:0];
    return r;
  endfunction

  // Only the first block with a matching start goes away.
  function automatic heap_resp_t release_block(input logic [OutAddrW-1:0] addr);
    heap_resp_t r;
    int         i;
    int         slot;
    bit         hit;
    r.addr   = '0;
    r.status = STAT_NOT_FOUND;
    slot     = 0;
    hit      = 1'b0;
    for (i = 0; i < blk_count && !hit; i++) begin
      if (blk_start[i] == {1'b0, addr}) begin
        slot = i;
        hit  = 1'b1;
      end
    end
    if (hit) begin
      for (i = slot; i + 1 < blk_count; i++) begin
        blk_start[i] = blk_start[i+1];
        blk_len[i]   = blk_len[i+1];
      end
      blk_count--;
      r.status = STAT_OK;
    end
    return r;
  endfunction

  // Predictions are made as each item is accepted, so a free that targets a live
  // block can take its address from the up-to-date list when it is presented.
  always @(posedge clk_i) begin
    heap_resp_t resp;
    if (rst_ni) begin
      if (offering && in_ready_o) begin
        if (cur_req.cmd == CMD_ALLOC) begin
          resp = place_block(cur_req.size);
          n_alloc++;
        end else begin
          resp = release_block(cur_req.addr);
          n_free++;
        end
        outcome_seen[resp.status]++;
        if (blk_count > peak_count) begin
          peak_count = blk_count;
        end
        awaited_resps = {awaited_resps, resp};
        offering = 1'b0;
      end
      if (!offering && pending_reqs.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        cur_req = pending_reqs.pop_front();
        if (cur_req.cmd == CMD_FREE && cur_req.pick_live && blk_count != 0) begin
          cur_req.addr = blk_start[$urandom_range(0, blk_count - 1)][OutAddrW-1:0];
        end
        offering = 1'b1;
      end
      in_valid_i      <= offering;
      cmd_i           <= cur_req.cmd;
      request_size_i  <= cur_req.size;
      block_address_i <= cur_req.addr;
    end
  end

  always @(posedge clk_i) begin
    heap_resp_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        n_results++;
        if (awaited_resps.size() == 0) begin
          note_mismatch("unexpected result, address", '0, 32'(granted_address_o));
        end else begin
          want = awaited_resps.pop_front();
          if (granted_address_o !== want.addr) begin
            note_mismatch("granted_address", 32'(want.addr), 32'(granted_address_o));
          end
          if (status_o !== want.status) begin
            note_mismatch("status", 32'(want.status), 32'(status_o));
          end
        end
      end
      out_ready_i <= (hold_left == 0) && ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // One long receiver hold-off, so the block backs up onto its input.
  always @(posedge clk_i) begin
    if (hold_arm && !hold_taken) begin
      hold_left  <= 400;
      hold_taken <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic apb_access(input bit wr, input logic [2:0] a, input logic [31:0] d,
                            output logic [31:0] rd);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_bounds(input logic [AddrW-1:0] lo, input logic [AddrW-1:0] hi);
    logic [31:0] rd;
    apb_access(1'b1, REG_HEAP_START, {10'd0, lo}, rd);
    apb_access(1'b1, REG_HEAP_END, {10'd0, hi}, rd);
    heap_lo = lo;
    heap_hi = hi;
    apb_access(1'b0, REG_HEAP_START, '0, rd);
    if (rd[AddrW-1:0] !== lo) begin
      note_mismatch("heap_start readback", 32'(lo), rd);
    end
    apb_access(1'b0, REG_HEAP_END, '0, rd);
    if (rd[AddrW-1:0] !== hi) begin
      note_mismatch("heap_end readback", 32'(hi), rd);
    end
    n_settings++;
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || offering || awaited_resps.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (MAX_ENTRIES + 10) @(posedge clk_i);
  endtask

  function automatic void push_req(input cmd_e c, input logic [AddrW-1:0] s,
                                   input logic [OutAddrW-1:0] a);
    heap_req_t q;
    q.cmd       = c;
    q.size      = s;
    q.addr      = a;
    q.pick_live = 1'b0;
    pending_reqs = {pending_reqs, q};
  endfunction

  // Frees mostly aim at live blocks; the unused field always carries noise.
  function automatic void queue_random(input int n, input int alloc_pct,
                                       input logic [AddrW-1:0] cap);
    heap_req_t q;
    int        k;
    int        roll;
    for (k = 0; k < n; k++) begin
      q.addr      = OutAddrW'($urandom_range(0, (1 << OutAddrW) - 1));
      q.pick_live = $urandom_range(0, 99) < 70;
      q.size      = AddrW'($urandom_range(0, RAM_SIZE));
      q.cmd       = CMD_FREE;
      if ($urandom_range(0, 99) < alloc_pct) begin
        q.cmd = CMD_ALLOC;
        roll  = $urandom_range(0, 99);
        if (roll < 10) begin
          q.size = '0;
        end else if (roll < 14) begin
          q.size = AddrW'($urandom_range(0, RAM_SIZE));
        end else if (roll < 16) begin
          q.size = SIZE_TOP;
        end else begin
          q.size = AddrW'($urandom_range(1, cap));
        end
      end
      pending_reqs = {pending_reqs, q};
    end
  endfunction

  task automatic run_phase(input logic [AddrW-1:0] lo, input logic [AddrW-1:0] hi,
                           input int n, input int alloc_pct, input logic [AddrW-1:0] cap,
                           input idle_mode_e mode, input bit pressure);
    set_bounds(lo, hi);
    case (mode)
      IDLE_NONE: begin
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
      end
      IDLE_SENDER: begin
        tx_idle_pct  = 65;
        rx_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        tx_idle_pct  = 0;
        rx_stall_pct = 65;
      end
      default: begin
        tx_idle_pct  = 7;
        rx_stall_pct = 7;
      end
    endcase
    queue_random(n, alloc_pct, cap);
    if (pressure) begin
      hold_arm <= 1'b1;
    end
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset bounds: zero-size placement, duplicate starts, misses and exact fits.
    push_req(CMD_ALLOC, 22'h0, 21'h0);
    push_req(CMD_ALLOC, 22'h100, 21'h0);
    push_req(CMD_FREE, 22'h0, 21'h1000);
    push_req(CMD_FREE, 22'h3FFFFF, 21'h1234);
    push_req(CMD_FREE, 22'h0, 21'h1FFFFF);
    push_req(CMD_ALLOC, SIZE_TOP, 21'h1FFFFF);
    push_req(CMD_ALLOC, 22'h1FEF00, 21'h0);
    push_req(CMD_ALLOC, 22'h1, 21'h0);
    push_req(CMD_FREE, 22'h0, 21'h1000);
    push_req(CMD_ALLOC, 22'h80, 21'h0);
    push_req(CMD_ALLOC, 22'h100, 21'h0);
    push_req(CMD_ALLOC, 22'h80, 21'h0);
    push_req(CMD_FREE, 22'h0, 21'h1100);
    push_req(CMD_FREE, 22'h0, 21'h1000);
    push_req(CMD_FREE, 22'h0, 21'h1080);
    wait_drained();

    run_phase(22'h001000, 22'h009000, 120, 75, 22'h400, IDLE_NONE, 1'b1);
    run_phase(22'h002000, 22'h006000, 110, 50, 22'h800, IDLE_SENDER, 1'b0);
    run_phase(22'h000000, 22'h200000, 100, 55, 22'h40000, IDLE_RECEIVER, 1'b0);
    run_phase(22'h008000, 22'h00C000, 110, 50, 22'h300, IDLE_BOTH, 1'b0);
    run_phase(22'h001000, 22'h020000, 110, 45, 22'h2000, IDLE_NONE, 1'b0);
    run_phase(22'h000100, 22'h1F0000, 100, 50, 22'h100000, IDLE_SENDER, 1'b0);
    run_phase(22'h004000, 22'h008000, 100, 60, 22'h200, IDLE_RECEIVER, 1'b0);
    run_phase(22'h001000, 22'h010000, 100, 40, 22'h800, IDLE_BOTH, 1'b0);

    // Start above end, and a start past the reportable address range. A block
    // granted at 2^21 cannot be freed again, so this comes last.
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    set_bounds(22'h200000, 22'h000000);
    push_req(CMD_ALLOC, 22'h0, 21'h0);
    push_req(CMD_ALLOC, 22'h1, 21'h0);
    push_req(CMD_FREE, 22'h0, 21'h0);
    wait_drained();
    set_bounds(22'h003000, 22'h002000);
    push_req(CMD_ALLOC, 22'h0, 21'h0);
    push_req(CMD_ALLOC, 22'h1, 21'h0);
    push_req(CMD_FREE, 22'h0, 21'h3000);
    push_req(CMD_FREE, 22'h0, 21'h3000);
    wait_drained();

    $display("covered %0d requests (%0d allocate, %0d free) over %0d bound settings, %0s %0d/%0d",
             n_alloc + n_free, n_alloc, n_free, n_settings, "peak occupancy", peak_count,
             MAX_ENTRIES);
    $display("outcomes: %0d ok, %0d no space, %0d not found, %0d full; %0d checked, %0d bad",
             outcome_seen[STAT_OK], outcome_seen[STAT_NO_SPACE], outcome_seen[STAT_NOT_FOUND],
             outcome_seen[STAT_FULL], n_results, mismatches);
    if (mismatches == 0) begin
      $display("first_fit_block_allocator_core_tb: done, clean");
    end else begin
      $display("first_fit_block_allocator_core_tb: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
src/fab_pkg.sv
src/fab_ctrl.sv
src/fab_dpath.sv
src/first_fit_block_allocator_core.sv
verif/first_fit_block_allocator_core_tb.sv
